>>> src/lsegt_pkg.sv
// Package for the lazy segment tree unit: operation codes, the node entry
// layout and the reset modulus. No dependencies.
`default_nettype none
package lsegt_pkg;

  localparam int unsigned WORD_W = 31;
  localparam logic [WORD_W-1:0] MODULUS_RESET = 31'd1000000007;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_MUL   = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mul_tag;
    logic [WORD_W-1:0] add_tag;
  } node_entry_t;

endpackage
`default_nettype wire

>>> src/lazy_segment_tree_mod_add_mul_unit.sv
// Lazy segment tree with modular range multiply, range add, point set and
// range sum query. Node state is kept in one synchronous memory.
// Depends on lsegt_pkg.
// After reset a clearing pass initializes all 4*NUM_ELEMENTS nodes; no input
// transfer is taken during it. An item runs through an operand reduction, then
// one memory access per step of the tree walk and a tag application where the
// walk calls for one; its pace is set by the shared one-bit-per-cycle modular
// reducer and the single memory port. One item is processed at a time; a result
// waits in an output register.
`default_nettype none
module lazy_segment_tree_mod_add_mul_unit
  import lsegt_pkg::*;
#(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              modulus_valid,
  output logic                   modulus_ready,
  input  wire logic [WORD_W-1:0] modulus,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        operation,
  input  wire logic [9:0]        left_index,
  input  wire logic [9:0]        right_index,
  input  wire logic [WORD_W-1:0] operand_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      range_sum,
  output logic                   status
);

  localparam int unsigned IW = $clog2(NUM_ELEMENTS);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = (IW > 10) ? IW : 10;
  localparam int unsigned TREE_NODES = 4 * NUM_ELEMENTS;
  localparam int unsigned AW = $clog2(TREE_NODES);
  localparam int unsigned SD = IW + 1;
  localparam int unsigned SIW = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);

  typedef struct packed {
    logic [AW-1:0] nd;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic          ph;
  } frame_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_ENTER, S_SET_LD, S_Q_LD, S_Q_ACC,
    S_PD_LD, S_PD_R, S_PD_WR, S_DESC, S_RET, S_PL_RD, S_PL_RD2, S_PL_LD,
    S_PL_WR, S_AP_RD, S_AP_LD, S_AP_P2, S_AP_P3, S_AP_P4, S_AP_P5,
    S_AP_P6, S_AP_P7, S_AP_P8, S_RED, S_FIN
  } state_t;

  state_t state;
  state_t red_ret;
  state_t ap_ret;

  node_entry_t mem [TREE_NODES];
  node_entry_t rdata;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  node_entry_t mem_wd;

  logic [WORD_W-1:0] mod_value;
  logic [AW-1:0] clr_addr;
  logic [1:0] cur_op;
  logic [CW-1:0] l_idx;
  logic [CW-1:0] r_idx;
  logic [WORD_W-1:0] v_red;
  logic [WORD_W-1:0] op_m;
  logic [WORD_W-1:0] op_a;
  logic [WORD_W-1:0] acc;
  logic bad;

  logic [AW-1:0] nd;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  frame_t stk [SD];
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_m1;
  frame_t top;

  logic [WORD_W-1:0] pd_sum;
  logic [WORD_W-1:0] pl_a;
  logic [AW-1:0] ap_node;
  logic [LW-1:0] ap_len;
  logic [WORD_W-1:0] ap_m;
  logic [WORD_W-1:0] ap_a;
  logic [WORD_W-1:0] e_sum;
  logic [WORD_W-1:0] e_mul;
  logic [WORD_W-1:0] e_add;

  logic [WORD_W-1:0] mx;
  logic [WORD_W-1:0] my;
  logic [61:0] prod;
  logic [61:0] acc64;

  logic [63:0] red_val;
  logic [WORD_W-1:0] red_rem;
  logic [5:0] red_cnt;
  logic [WORD_W:0] red_t;
  logic [WORD_W:0] qsum;

  logic [IW:0] lohi;
  logic [IW-1:0] mid;
  logic [IW:0] top_lohi;
  logic [IW-1:0] top_mid;
  logic [AW-1:0] child_l;
  logic [AW-1:0] child_r;
  logic [CW-1:0] lo_c;
  logic [CW-1:0] hi_c;
  logic [CW-1:0] last_c;

  assign modulus_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  assign sp_m1 = sp - 1'b1;
  assign top = stk[sp_m1[SIW-1:0]];
  assign lohi = {1'b0, lo} + {1'b0, hi};
  assign mid = lohi[IW:1];
  assign top_lohi = {1'b0, top.lo} + {1'b0, top.hi};
  assign top_mid = top_lohi[IW:1];
  assign child_l = {nd[AW-2:0], 1'b0};
  assign child_r = {nd[AW-2:0], 1'b1};
  assign lo_c = CW'(lo);
  assign hi_c = CW'(hi);
  assign last_c = CW'(NUM_ELEMENTS - 1);
  assign red_t = {red_rem, red_val[63]};
  assign qsum = {1'b0, acc} + {1'b0, red_rem};

  always_comb begin
    mem_we = 1'b0;
    mem_addr = nd;
    mem_wd = '0;
    mx = '0;
    my = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_addr;
        mem_wd = '{sum: '0, mul_tag: 31'd1, add_tag: '0};
      end
      S_SET_LD: begin
        mem_we = 1'b1;
        mem_wd = '{sum: v_red, mul_tag: rdata.mul_tag, add_tag: rdata.add_tag};
      end
      S_PD_WR: begin
        mem_we = 1'b1;
        mem_wd = '{sum: pd_sum, mul_tag: 31'd1, add_tag: '0};
      end
      S_PL_RD: mem_addr = child_l;
      S_PL_RD2: mem_addr = child_r;
      S_PL_WR: begin
        mem_we = 1'b1;
        mem_wd = '{sum: red_rem, mul_tag: 31'd1, add_tag: '0};
      end
      S_AP_RD: mem_addr = ap_node;
      S_AP_LD: begin
        mx = rdata.sum;
        my = ap_m;
      end
      S_AP_P2: begin
        mx = ap_a;
        my = WORD_W'(ap_len);
      end
      S_AP_P4: begin
        mx = e_mul;
        my = ap_m;
      end
      S_AP_P6: begin
        mx = e_add;
        my = ap_m;
      end
      S_AP_P8: begin
        mem_we = 1'b1;
        mem_addr = ap_node;
        mem_wd = '{sum: e_sum, mul_tag: e_mul, add_tag: red_rem};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    prod <= mx * my;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      sp <= '0;
      mod_value <= MODULUS_RESET;
    end else begin
      if (modulus_valid) begin
        mod_value <= (modulus < 31'd2) ? 31'd2 : modulus;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TREE_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_op <= operation;
            l_idx <= CW'(left_index);
            r_idx <= CW'(right_index);
            acc <= '0;
            bad <= 1'b0;
            red_val <= 64'(operand_value);
            red_rem <= '0;
            red_cnt <= '0;
            red_ret <= S_START;
            state <= S_RED;
          end
        end
        S_START: begin
          v_red <= red_rem;
          op_m <= (cur_op == OP_MUL) ? red_rem : 31'd1;
          op_a <= (cur_op == OP_ADD) ? red_rem : '0;
          nd <= AW'(1);
          lo <= '0;
          hi <= IW'(NUM_ELEMENTS - 1);
          sp <= '0;
          if (cur_op == OP_SET) begin
            if (l_idx > last_c) begin
              state <= S_FIN;
            end else begin
              r_idx <= l_idx;
              state <= S_ENTER;
            end
          end else if (l_idx > r_idx) begin
            bad <= 1'b1;
            state <= S_FIN;
          end else if (l_idx > last_c) begin
            state <= S_FIN;
          end else begin
            if (r_idx > last_c) begin
              r_idx <= last_c;
            end
            state <= S_ENTER;
          end
        end
        S_ENTER: begin
          if (r_idx < lo_c || l_idx > hi_c) begin
            state <= S_RET;
          end else if (l_idx <= lo_c && hi_c <= r_idx) begin
            case (cur_op)
              OP_SET: state <= S_SET_LD;
              OP_QUERY: state <= S_Q_LD;
              default: begin
                ap_node <= nd;
                ap_len <= LW'(hi) - LW'(lo) + 1'b1;
                ap_m <= op_m;
                ap_a <= op_a;
                ap_ret <= S_RET;
                state <= S_AP_RD;
              end
            endcase
          end else begin
            state <= S_PD_LD;
          end
        end
        S_SET_LD: state <= S_RET;
        S_Q_LD: begin
          red_val <= 64'(rdata.sum);
          red_rem <= '0;
          red_cnt <= '0;
          red_ret <= S_Q_ACC;
          state <= S_RED;
        end
        S_Q_ACC: begin
          acc <= (qsum >= {1'b0, mod_value}) ? WORD_W'(qsum - {1'b0, mod_value})
                                              : qsum[WORD_W-1:0];
          state <= S_RET;
        end
        S_PD_LD: begin
          pd_sum <= rdata.sum;
          if (rdata.mul_tag == 31'd1 && rdata.add_tag == '0) begin
            state <= S_DESC;
          end else begin
            ap_node <= child_l;
            ap_len <= LW'(mid) - LW'(lo) + 1'b1;
            ap_m <= rdata.mul_tag;
            ap_a <= rdata.add_tag;
            ap_ret <= S_PD_R;
            state <= S_AP_RD;
          end
        end
        S_PD_R: begin
          ap_node <= child_r;
          ap_len <= LW'(hi) - LW'(mid);
          ap_ret <= S_PD_WR;
          state <= S_AP_RD;
        end
        S_PD_WR: state <= S_DESC;
        S_DESC: begin
          stk[sp[SIW-1:0]] <= '{nd: nd, lo: lo, hi: hi, ph: 1'b0};
          sp <= sp + 1'b1;
          nd <= child_l;
          hi <= mid;
          state <= S_ENTER;
        end
        S_RET: begin
          if (sp == '0) begin
            state <= S_FIN;
          end else if (!top.ph) begin
            stk[sp_m1[SIW-1:0]].ph <= 1'b1;
            nd <= {top.nd[AW-2:0], 1'b1};
            lo <= top_mid + 1'b1;
            hi <= top.hi;
            state <= S_ENTER;
          end else begin
            sp <= sp_m1;
            nd <= top.nd;
            lo <= top.lo;
            hi <= top.hi;
            state <= (cur_op == OP_QUERY) ? S_RET : S_PL_RD;
          end
        end
        S_PL_RD: state <= S_PL_RD2;
        S_PL_RD2: begin
          pl_a <= rdata.sum;
          state <= S_PL_LD;
        end
        S_PL_LD: begin
          red_val <= 64'(pl_a) + 64'(rdata.sum);
          red_rem <= '0;
          red_cnt <= '0;
          red_ret <= S_PL_WR;
          state <= S_RED;
        end
        S_PL_WR: state <= S_RET;
        S_AP_RD: state <= S_AP_LD;
        S_AP_LD: begin
          e_sum <= rdata.sum;
          e_mul <= rdata.mul_tag;
          e_add <= rdata.add_tag;
          state <= S_AP_P2;
        end
        S_AP_P2: begin
          acc64 <= prod;
          state <= S_AP_P3;
        end
        S_AP_P3: begin
          red_val <= 64'(acc64) + 64'(prod);
          red_rem <= '0;
          red_cnt <= '0;
          red_ret <= S_AP_P4;
          state <= S_RED;
        end
        S_AP_P4: begin
          e_sum <= red_rem;
          state <= S_AP_P5;
        end
        S_AP_P5: begin
          red_val <= 64'(prod);
          red_rem <= '0;
          red_cnt <= '0;
          red_ret <= S_AP_P6;
          state <= S_RED;
        end
        S_AP_P6: begin
          e_mul <= red_rem;
          state <= S_AP_P7;
        end
        S_AP_P7: begin
          red_val <= 64'(prod) + 64'(ap_a);
          red_rem <= '0;
          red_cnt <= '0;
          red_ret <= S_AP_P8;
          state <= S_RED;
        end
        S_AP_P8: state <= ap_ret;
        S_RED: begin
          red_rem <= (red_t >= {1'b0, mod_value}) ? WORD_W'(red_t - {1'b0, mod_value})
                                                   : red_t[WORD_W-1:0];
          red_val <= {red_val[62:0], 1'b0};
          red_cnt <= red_cnt + 1'b1;
          if (red_cnt == 6'd63) begin
            state <= red_ret;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            range_sum <= (cur_op == OP_QUERY) ? acc : '0;
            status <= bad;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) sp <= SPW'(SD))
    else $error("Walk stack overflow.");
  assert property (@(posedge clk) disable iff (rst) (state == S_RED) |-> red_rem < mod_value)
    else $error("Reducer remainder reached the modulus.");
  assert property (@(posedge clk) disable iff (rst) (state == S_Q_ACC) |=> acc < mod_value)
    else $error("Query accumulator is not reduced.");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !mem_we)
    else $error("Node memory written while idle.");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for lazy_segment_tree_mod_add_mul_unit: a directed
// table, then random phases with several moduli and idle patterns.
// Depends on lsegt_pkg and the unit; carries its own tree predictor.
module tb_top
  import lsegt_pkg::*;
;

  localparam int NODES = 4096;
  localparam int LAST = 1023;

  typedef struct {
    logic [WORD_W-1:0] sum;
    logic              st;
  } result_t;

  typedef struct {
    logic [1:0]        op;
    logic [9:0]        l;
    logic [9:0]        r;
    logic [WORD_W-1:0] v;
    bit                typed;
    logic [WORD_W-1:0] esum;
    logic              est;
  } row_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              modulus_valid = 0;
  logic              modulus_ready;
  logic [WORD_W-1:0] modulus = '0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        operation = '0;
  logic [9:0]        left_index = '0;
  logic [9:0]        right_index = '0;
  logic [WORD_W-1:0] operand_value = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [WORD_W-1:0] range_sum;
  logic              status;

  lazy_segment_tree_mod_add_mul_unit u_dut (
    .clk(clk), .rst(rst),
    .modulus_valid(modulus_valid), .modulus_ready(modulus_ready), .modulus(modulus),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .left_index(left_index), .right_index(right_index), .operand_value(operand_value),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum), .status(status)
  );

  always #5 clk = ~clk;

  longint unsigned tree_sum [NODES];
  longint unsigned tree_mul [NODES];
  longint unsigned tree_add [NODES];
  longint unsigned cur_modulus;
  result_t pending_results[$];
  int error_count = 0;
  int send_idle = 0;
  int recv_stall = 0;

  function automatic void tag_node(int nd, longint unsigned len, longint unsigned m,
                                   longint unsigned a);
    tree_sum[nd] = (tree_sum[nd] * m + a * len) % cur_modulus;
    tree_mul[nd] = (tree_mul[nd] * m) % cur_modulus;
    tree_add[nd] = (tree_add[nd] * m + a) % cur_modulus;
  endfunction

  function automatic void push_tags(int nd, int lo, int hi);
    int mid;
    mid = (lo + hi) / 2;
    if (tree_mul[nd] == 1 && tree_add[nd] == 0) return;
    tag_node(2 * nd, 64'(mid - lo + 1), tree_mul[nd], tree_add[nd]);
    tag_node(2 * nd + 1, 64'(hi - mid), tree_mul[nd], tree_add[nd]);
    tree_mul[nd] = 1;
    tree_add[nd] = 0;
  endfunction

  function automatic void set_leaf(int nd, int lo, int hi, int pos, longint unsigned v);
    int mid;
    mid = (lo + hi) / 2;
    if (lo == hi) begin
      tree_sum[nd] = v;
      return;
    end
    push_tags(nd, lo, hi);
    if (pos <= mid) set_leaf(2 * nd, lo, mid, pos, v);
    else set_leaf(2 * nd + 1, mid + 1, hi, pos, v);
    tree_sum[nd] = (tree_sum[2 * nd] + tree_sum[2 * nd + 1]) % cur_modulus;
  endfunction

  function automatic void tag_range(int nd, int lo, int hi, int l, int r,
                                    longint unsigned m, longint unsigned a);
    int mid;
    mid = (lo + hi) / 2;
    if (r < lo || l > hi) return;
    if (l <= lo && hi <= r) begin
      tag_node(nd, 64'(hi - lo + 1), m, a);
      return;
    end
    push_tags(nd, lo, hi);
    tag_range(2 * nd, lo, mid, l, r, m, a);
    tag_range(2 * nd + 1, mid + 1, hi, l, r, m, a);
    tree_sum[nd] = (tree_sum[2 * nd] + tree_sum[2 * nd + 1]) % cur_modulus;
  endfunction

  function automatic longint unsigned sum_range(int nd, int lo, int hi, int l, int r);
    int mid;
    mid = (lo + hi) / 2;
    if (r < lo || l > hi) return 0;
    if (l <= lo && hi <= r) return tree_sum[nd] % cur_modulus;
    push_tags(nd, lo, hi);
    return (sum_range(2 * nd, lo, mid, l, r) + sum_range(2 * nd + 1, mid + 1, hi, l, r))
           % cur_modulus;
  endfunction

  function automatic result_t predict_tree(logic [1:0] op, int l, int r,
                                           longint unsigned raw);
    result_t res;
    longint unsigned v;
    v = raw % cur_modulus;
    res.sum = '0;
    res.st = 1'b0;
    if (op == OP_SET) begin
      set_leaf(1, 0, LAST, l, v);
    end else if (l > r) begin
      res.st = 1'b1;
    end else begin
      case (op)
        OP_MUL: tag_range(1, 0, LAST, l, r, v, 64'd0);
        OP_ADD: tag_range(1, 0, LAST, l, r, 64'd1, v);
        default: res.sum = WORD_W'(sum_range(1, 0, LAST, l, r));
      endcase
    end
    return res;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result sum=%0d status=%0d", $time, range_sum, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (range_sum !== want.sum) begin
          $display("%0t: range_sum expected %0d actual %0d", $time, want.sum, range_sum);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(row_t row);
    result_t res;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= row.op;
    left_index <= row.l;
    right_index <= row.r;
    operand_value <= row.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_tree(row.op, int'(row.l), int'(row.r), 64'(row.v));
    if (row.typed) begin
      res.sum = row.esum;
      res.st = row.est;
    end
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic write_modulus(logic [WORD_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    modulus_valid <= 1'b1;
    modulus <= val;
    @(posedge clk);
    while (!modulus_ready) @(posedge clk);
    cur_modulus = (val < 2) ? 64'd2 : 64'(val);
    @(negedge clk);
    modulus_valid <= 1'b0;
  endtask

  function automatic row_t mk(logic [1:0] op, int l, int r, longint unsigned v,
                              bit typed = 0, longint unsigned esum = 0, bit est = 0);
    row_t row;
    row.op = op;
    row.l = 10'(l);
    row.r = 10'(r);
    row.v = WORD_W'(v);
    row.typed = typed;
    row.esum = WORD_W'(esum);
    row.est = est;
    return row;
  endfunction

  function automatic row_t random_row();
    row_t row;
    int l;
    int w;
    int pick;
    row.op = 2'($urandom_range(3));
    l = $urandom_range(LAST);
    pick = $urandom_range(99);
    if (pick < 55) w = $urandom_range(15);
    else if (pick < 80) w = $urandom_range(200);
    else w = $urandom_range(LAST);
    row.l = 10'(l);
    row.r = (l + w > LAST) ? 10'(LAST) : 10'(l + w);
    if ($urandom_range(99) < 12) row.r = 10'($urandom_range(LAST));
    if ($urandom_range(99) < 70) row.v = WORD_W'($urandom());
    else row.v = WORD_W'($urandom_range(10));
    row.typed = 0;
    return row;
  endfunction

  row_t directed[$];
  logic [WORD_W-1:0] phase_mod[8];

  initial begin
    for (int i = 0; i < NODES; i++) begin
      tree_sum[i] = 0;
      tree_mul[i] = 1;
      tree_add[i] = 0;
    end
    cur_modulus = 64'(MODULUS_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed.push_back(mk(OP_QUERY, 0, LAST, 0, 1, 0, 0));
    directed.push_back(mk(OP_SET, 0, 0, 31'h7fffffff, 1, 0, 0));
    directed.push_back(mk(OP_SET, LAST, 0, 5, 1, 0, 0));
    directed.push_back(mk(OP_QUERY, 0, 0, 0, 1, 147483633, 0));
    directed.push_back(mk(OP_QUERY, LAST, LAST, 0, 1, 5, 0));
    directed.push_back(mk(OP_QUERY, 0, LAST, 0, 1, 147483638, 0));
    directed.push_back(mk(OP_MUL, 5, 3, 7, 1, 0, 1));
    directed.push_back(mk(OP_ADD, 10, 9, 3, 1, 0, 1));
    directed.push_back(mk(OP_QUERY, 1, 0, 0, 1, 0, 1));
    directed.push_back(mk(OP_ADD, 0, LAST, 31'h7fffffff));
    directed.push_back(mk(OP_MUL, 0, 511, 3));
    directed.push_back(mk(OP_ADD, 512, LAST, 1));
    directed.push_back(mk(OP_QUERY, 0, LAST, 0));
    directed.push_back(mk(OP_QUERY, 300, 700, 0));
    directed.push_back(mk(OP_SET, 700, 0, 1));
    directed.push_back(mk(OP_QUERY, 700, 700, 0));
    directed.push_back(mk(OP_MUL, 0, LAST, 31'h7fffffff));
    directed.push_back(mk(OP_QUERY, 0, LAST, 0));
    directed.push_back(mk(OP_QUERY, LAST, 0, 0, 1, 0, 1));
    directed.push_back(mk(OP_MUL, 0, LAST, 0));
    directed.push_back(mk(OP_QUERY, 0, LAST, 0, 1, 0, 0));
    foreach (directed[i]) send_item(directed[i]);

    phase_mod[0] = 31'h7fffffff;
    phase_mod[1] = '0;
    phase_mod[2] = WORD_W'(13);
    phase_mod[3] = WORD_W'(1);
    phase_mod[4] = MODULUS_RESET;
    phase_mod[5] = WORD_W'($urandom() | 32'h40000000);
    phase_mod[6] = WORD_W'(2);
    phase_mod[7] = WORD_W'($urandom_range(1000, 3));
    for (int p = 0; p < 8; p++) begin
      write_modulus(phase_mod[p]);
      send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 60 : 24) : 0;
      recv_stall = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 60 : 24) : 0;
      for (int n = 0; n < 200; n++) send_item(random_row());
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("** lazy_segment_tree_mod_add_mul_unit: PASSED **");
    end else begin
      $display("** lazy_segment_tree_mod_add_mul_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000000;
    $display("%0t: timeout", $time);
    $display("** lazy_segment_tree_mod_add_mul_unit: FAILED **");
    $finish;
  end

endmodule
